>>> hw/rtl/mvca_pkg.sv
`timescale 1ns / 1ps
package mvca_pkg;

   localparam int COORD_W = 12;
   localparam int VOL_W   = 50;
   localparam int CEN_W   = 20;
   localparam int WSUM_W  = 64;
   localparam int CROSS_W = 2 * COORD_W + 1;
   localparam int TRI_W   = CROSS_W + COORD_W + 2;
   localparam int VSUM_W  = COORD_W + 2;
   localparam int PROD_W  = TRI_W + VSUM_W;
   localparam int FRAC_W  = 6;
   localparam int QUO_W   = CEN_W + 1;
   localparam int NUM_W   = WSUM_W + FRAC_W + 2;
   localparam int DEN_W   = VOL_W + 1;
   localparam int REM_W   = DEN_W + 1;
   localparam int QDEPTH  = 2;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] az;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic signed [COORD_W-1:0] bz;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
      logic                      last;
   } tri_type;

   typedef struct packed {
      logic signed [VOL_W-1:0] six_volume;
      logic signed [CEN_W-1:0] centre_x;
      logic signed [CEN_W-1:0] centre_y;
      logic signed [CEN_W-1:0] centre_z;
      logic                    zero_volume;
      logic                    count_overflow;
   } res_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_CROSS,
      CS_TRIPLE,
      CS_WEIGHT,
      CS_DSTART,
      CS_DWAIT,
      CS_DONE
   } core_state_type;

   typedef enum logic [1:0] {
      DS_IDLE,
      DS_CHECK,
      DS_RUN,
      DS_DONE
   } div_state_type;

endpackage

>>> hw/rtl/mvca_front.sv
`timescale 1ns / 1ps
module mvca_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [mvca_pkg::COORD_W-1:0]  ax,
   input  logic [mvca_pkg::COORD_W-1:0]  ay,
   input  logic [mvca_pkg::COORD_W-1:0]  az,
   input  logic [mvca_pkg::COORD_W-1:0]  bx,
   input  logic [mvca_pkg::COORD_W-1:0]  by,
   input  logic [mvca_pkg::COORD_W-1:0]  bz,
   input  logic [mvca_pkg::COORD_W-1:0]  cx,
   input  logic [mvca_pkg::COORD_W-1:0]  cy,
   input  logic [mvca_pkg::COORD_W-1:0]  cz,
   input  logic                          last,
   output logic                          q_valid,
   input  logic                          q_pop,
   output mvca_pkg::tri_type             q_item
);
   import mvca_pkg::*;

   localparam int PTR_W = $clog2(QDEPTH);

   tri_type            mem_ff [QDEPTH];
   tri_type            item_in;
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;
   logic               wr_en, rd_en;

   // only the low coordinate bits count, sign extended
   always_comb begin
      item_in.ax   = COORD_W'(signed'(ax[COORD_BITS-1:0]));
      item_in.ay   = COORD_W'(signed'(ay[COORD_BITS-1:0]));
      item_in.az   = COORD_W'(signed'(az[COORD_BITS-1:0]));
      item_in.bx   = COORD_W'(signed'(bx[COORD_BITS-1:0]));
      item_in.by   = COORD_W'(signed'(by[COORD_BITS-1:0]));
      item_in.bz   = COORD_W'(signed'(bz[COORD_BITS-1:0]));
      item_in.cx   = COORD_W'(signed'(cx[COORD_BITS-1:0]));
      item_in.cy   = COORD_W'(signed'(cy[COORD_BITS-1:0]));
      item_in.cz   = COORD_W'(signed'(cz[COORD_BITS-1:0]));
      item_in.last = last;
   end

   assign full    = (cnt_ff == (PTR_W+1)'(QDEPTH));
   assign q_valid = (cnt_ff != '0);
   assign q_item  = mem_ff[rd_ff];
   assign wr_en   = push && !full;
   assign rd_en   = q_pop && q_valid;

   always_comb begin
      wr_in  = wr_en ? PTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = rd_en ? PTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(wr_en) - (PTR_W+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/mvca_div.sv
`timescale 1ns / 1ps
module mvca_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [mvca_pkg::WSUM_W-1:0]  wsum,
   input  logic signed [mvca_pkg::VOL_W-1:0]   vol,
   output logic                                done,
   output logic signed [mvca_pkg::CEN_W-1:0]   centre
);
   import mvca_pkg::*;

   localparam int BIT_W = $clog2(QUO_W);
   localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1) << (CEN_W - 1);
   localparam logic [QUO_W-1:0] POS_LIM = NEG_LIM - 1'b1;

   div_state_type      state_ff, state_in;
   logic [NUM_W-1:0]   num_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [REM_W-1:0]   rem_ff, rem_shift;
   logic [QUO_W-1:0]   nlo_ff, quo_ff, mag;
   logic [BIT_W-1:0]   bit_ff;
   logic               neg_ff, sat_ff, sat_in;
   logic [WSUM_W-1:0]  aw;
   logic [VOL_W-1:0]   av;

   assign aw = wsum[WSUM_W-1] ? WSUM_W'(-wsum) : WSUM_W'(wsum);
   assign av = vol[VOL_W-1] ? VOL_W'(-vol) : VOL_W'(vol);

   // quotient of 128*|w| + |v| over 2*|v| is the rounded centre
   assign sat_in    = num_ff >= {den_ff, {QUO_W{1'b0}}};
   assign rem_shift = {rem_ff[REM_W-2:0], nlo_ff[QUO_W-1]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         DS_IDLE:  if (start) state_in = DS_CHECK;
         DS_CHECK: state_in = sat_in ? DS_DONE : DS_RUN;
         DS_RUN:   if (bit_ff == '0) state_in = DS_DONE;
         DS_DONE:  state_in = DS_IDLE;
         default:  state_in = DS_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == DS_DONE);
      mag  = sat_ff ? NEG_LIM : quo_ff;
      if (neg_ff) begin
         centre = CEN_W'(-{1'b0, (mag > NEG_LIM) ? NEG_LIM : mag});
      end else begin
         centre = CEN_W'((mag > POS_LIM) ? POS_LIM : mag);
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         DS_IDLE: begin
            num_ff <= NUM_W'({aw, {(FRAC_W+1){1'b0}}}) + NUM_W'(av);
            den_ff <= {av, 1'b0};
            neg_ff <= wsum[WSUM_W-1] != vol[VOL_W-1];
         end
         DS_CHECK: begin
            sat_ff <= sat_in;
            rem_ff <= REM_W'(num_ff[NUM_W-1:QUO_W]);
            nlo_ff <= num_ff[QUO_W-1:0];
            quo_ff <= '0;
            bit_ff <= BIT_W'(QUO_W - 1);
         end
         DS_RUN: begin
            nlo_ff <= {nlo_ff[QUO_W-2:0], 1'b0};
            bit_ff <= bit_ff - 1'b1;
            if (rem_shift >= REM_W'(den_ff)) begin
               rem_ff <= rem_shift - REM_W'(den_ff);
               quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_shift;
               quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/mvca_core.sv
`timescale 1ns / 1ps
module mvca_core #(
   parameter int MAX_TRIANGLES = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_pop,
   input  mvca_pkg::tri_type      q_item,
   input  logic                   res_ready,
   output logic                   res_load,
   output mvca_pkg::res_type      res
);
   import mvca_pkg::*;

   localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);

   core_state_type              state_ff, state_in;
   tri_type                     item_ff;
   logic signed [CROSS_W-1:0]   x_ff [3];
   logic signed [VSUM_W-1:0]    s_ff [3];
   logic signed [TRI_W-1:0]     t_ff;
   logic signed [VOL_W-1:0]     vol_ff;
   logic signed [WSUM_W-1:0]    w_ff [3];
   logic signed [CEN_W-1:0]     cen_ff [3];
   logic [CNT_W-1:0]            cnt_ff;
   logic                        ovf_ff;
   logic [1:0]                  axis_ff;
   logic                        div_start, div_done;
   logic signed [CEN_W-1:0]     div_centre;
   logic                        room;

   assign room = cnt_ff < CNT_W'(MAX_TRIANGLES);

   mvca_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .wsum   (w_ff[axis_ff]),
      .vol    (vol_ff),
      .done   (div_done),
      .centre (div_centre)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE:   if (q_valid) state_in = CS_CROSS;
         CS_CROSS:  state_in = CS_TRIPLE;
         CS_TRIPLE: state_in = CS_WEIGHT;
         CS_WEIGHT: state_in = item_ff.last ? CS_DSTART : CS_IDLE;
         CS_DSTART: state_in = CS_DWAIT;
         CS_DWAIT:  if (div_done) state_in = (axis_ff == 2'd2) ? CS_DONE : CS_DSTART;
         CS_DONE:   if (res_ready) state_in = CS_IDLE;
         default:   state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      q_pop        = (state_ff == CS_IDLE) && q_valid;
      div_start    = (state_ff == CS_DSTART);
      res_load     = (state_ff == CS_DONE) && res_ready;
      res.six_volume     = vol_ff;
      res.zero_volume    = (vol_ff == '0);
      res.centre_x       = res.zero_volume ? '0 : cen_ff[0];
      res.centre_y       = res.zero_volume ? '0 : cen_ff[1];
      res.centre_z       = res.zero_volume ? '0 : cen_ff[2];
      res.count_overflow = ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (state_ff == CS_CROSS) begin
         x_ff[0] <= CROSS_W'(item_ff.by) * CROSS_W'(item_ff.cz)
                  - CROSS_W'(item_ff.bz) * CROSS_W'(item_ff.cy);
         x_ff[1] <= CROSS_W'(item_ff.bz) * CROSS_W'(item_ff.cx)
                  - CROSS_W'(item_ff.bx) * CROSS_W'(item_ff.cz);
         x_ff[2] <= CROSS_W'(item_ff.bx) * CROSS_W'(item_ff.cy)
                  - CROSS_W'(item_ff.by) * CROSS_W'(item_ff.cx);
         s_ff[0] <= VSUM_W'(item_ff.ax) + VSUM_W'(item_ff.bx) + VSUM_W'(item_ff.cx);
         s_ff[1] <= VSUM_W'(item_ff.ay) + VSUM_W'(item_ff.by) + VSUM_W'(item_ff.cy);
         s_ff[2] <= VSUM_W'(item_ff.az) + VSUM_W'(item_ff.bz) + VSUM_W'(item_ff.cz);
      end
      if (state_ff == CS_TRIPLE) begin
         t_ff <= TRI_W'(item_ff.ax) * TRI_W'(x_ff[0])
               + TRI_W'(item_ff.ay) * TRI_W'(x_ff[1])
               + TRI_W'(item_ff.az) * TRI_W'(x_ff[2]);
      end
      if (state_ff == CS_DWAIT && div_done) begin
         cen_ff[axis_ff] <= div_centre;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || res_load) begin
         vol_ff  <= '0;
         w_ff[0] <= '0;
         w_ff[1] <= '0;
         w_ff[2] <= '0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (state_ff == CS_WEIGHT) begin
         if (room) begin
            vol_ff  <= vol_ff + VOL_W'(t_ff);
            w_ff[0] <= w_ff[0] + WSUM_W'(PROD_W'(t_ff) * PROD_W'(s_ff[0]));
            w_ff[1] <= w_ff[1] + WSUM_W'(PROD_W'(t_ff) * PROD_W'(s_ff[1]));
            w_ff[2] <= w_ff[2] + WSUM_W'(PROD_W'(t_ff) * PROD_W'(s_ff[2]));
            cnt_ff  <= cnt_ff + 1'b1;
         end else begin
            ovf_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == CS_WEIGHT) begin
            axis_ff <= '0;
         end else if (state_ff == CS_DWAIT && div_done) begin
            axis_ff <= axis_ff + 1'b1;
         end
      end
   end

endmodule

>>> hw/rtl/mesh_volume_centroid_accumulator_unit.sv
`timescale 1ns / 1ps
// each triangle passes the queue, then the cross, triple and weight steps of the back end
// a last triangle adds three runs of the shared one-bit-per-cycle divider and the output load
// the back end takes one triangle at a time, bound by the sequential multiply/accumulate steps
// reset: synchronous, clears queue, sums, triangle count and the result valid flag
module mesh_volume_centroid_accumulator_unit #(
   parameter int MAX_TRIANGLES = 4096,
   parameter int COORD_BITS    = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [mvca_pkg::COORD_W-1:0]        req_ax,
   input  logic [mvca_pkg::COORD_W-1:0]        req_ay,
   input  logic [mvca_pkg::COORD_W-1:0]        req_az,
   input  logic [mvca_pkg::COORD_W-1:0]        req_bx,
   input  logic [mvca_pkg::COORD_W-1:0]        req_by,
   input  logic [mvca_pkg::COORD_W-1:0]        req_bz,
   input  logic [mvca_pkg::COORD_W-1:0]        req_cx,
   input  logic [mvca_pkg::COORD_W-1:0]        req_cy,
   input  logic [mvca_pkg::COORD_W-1:0]        req_cz,
   input  logic                                req_last_triangle,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [mvca_pkg::VOL_W-1:0]   rsp_six_volume,
   output logic signed [mvca_pkg::CEN_W-1:0]   rsp_centre_x,
   output logic signed [mvca_pkg::CEN_W-1:0]   rsp_centre_y,
   output logic signed [mvca_pkg::CEN_W-1:0]   rsp_centre_z,
   output logic                                rsp_zero_volume,
   output logic                                rsp_count_overflow
);
   import mvca_pkg::*;

   logic         q_valid, q_pop;
   tri_type      q_item;
   logic         res_ready, res_load;
   res_type      res, res_ff;
   logic         valid_ff;

   mvca_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .ax      (req_ax),
      .ay      (req_ay),
      .az      (req_az),
      .bx      (req_bx),
      .by      (req_by),
      .bz      (req_bz),
      .cx      (req_cx),
      .cy      (req_cy),
      .cz      (req_cz),
      .last    (req_last_triangle),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_item  (q_item)
   );

   assign res_ready = !valid_ff || pop;

   mvca_core #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_core (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .res_ready (res_ready),
      .res_load  (res_load),
      .res       (res)
   );

   // output register holds one finished beat
   always_ff @(posedge clock) begin
      if (res_load) begin
         res_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_load) begin
         valid_ff <= 1'b1;
      end else if (pop) begin
         valid_ff <= 1'b0;
      end
   end

   assign empty              = !valid_ff;
   assign rsp_six_volume     = res_ff.six_volume;
   assign rsp_centre_x       = res_ff.centre_x;
   assign rsp_centre_y       = res_ff.centre_y;
   assign rsp_centre_z       = res_ff.centre_z;
   assign rsp_zero_volume    = res_ff.zero_volume;
   assign rsp_count_overflow = res_ff.count_overflow;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!valid_ff || pop))
      else $error("result loaded over a waiting beat");

   a_zero_centre: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_zero_volume) |->
         (rsp_centre_x == '0 && rsp_centre_y == '0 && rsp_centre_z == '0))
      else $error("zero volume with nonzero centre");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result present after reset");

endmodule

>>> tb/mvca_checker.sv
`timescale 1ns / 1ps
module mvca_checker #(
   parameter int MAX_TRIANGLES = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic                                full,
   input  logic [mvca_pkg::COORD_W-1:0]        req_ax,
   input  logic [mvca_pkg::COORD_W-1:0]        req_ay,
   input  logic [mvca_pkg::COORD_W-1:0]        req_az,
   input  logic [mvca_pkg::COORD_W-1:0]        req_bx,
   input  logic [mvca_pkg::COORD_W-1:0]        req_by,
   input  logic [mvca_pkg::COORD_W-1:0]        req_bz,
   input  logic [mvca_pkg::COORD_W-1:0]        req_cx,
   input  logic [mvca_pkg::COORD_W-1:0]        req_cy,
   input  logic [mvca_pkg::COORD_W-1:0]        req_cz,
   input  logic                                req_last_triangle,
   input  logic                                empty,
   input  logic                                pop,
   input  logic signed [mvca_pkg::VOL_W-1:0]   rsp_six_volume,
   input  logic signed [mvca_pkg::CEN_W-1:0]   rsp_centre_x,
   input  logic signed [mvca_pkg::CEN_W-1:0]   rsp_centre_y,
   input  logic signed [mvca_pkg::CEN_W-1:0]   rsp_centre_z,
   input  logic                                rsp_zero_volume,
   input  logic                                rsp_count_overflow,
   output int                                  pending,
   output int                                  errors,
   output int                                  meshes_done,
   output int                                  overflow_meshes,
   output int                                  saturated_centres
);
   import mvca_pkg::*;

   localparam longint unsigned CEN_POS_MAX = (64'd1 << (CEN_W - 1)) - 1;
   localparam longint VOL_MAX = (64'sd1 <<< (VOL_W - 1)) - 1;

   res_type mesh_results[$];
   longint  six_vol_acc;
   longint  moment_acc [3];
   int      tri_seen;
   bit      too_many;

   assign pending = mesh_results.size();

   // weighted sum over 4 * volume, 8 fraction bits, round half away from zero
   function automatic logic [CEN_W-1:0] centre_of(longint w, longint v);
      longint unsigned aw, av, q, r, mag, frac;
      bit neg;
      aw = (w < 0) ? longint'(0) - w : w;
      av = (v < 0) ? longint'(0) - v : v;
      neg = (w < 0) != (v < 0);
      q = aw / av;
      r = aw % av;
      if (q >= (64'd1 << (CEN_W - FRAC_W))) begin
         mag = CEN_POS_MAX + 1;
      end else begin
         frac = ((r << (FRAC_W + 1)) + av) / (av << 1);
         mag = (q << FRAC_W) + frac;
      end
      if (neg) begin
         if (mag > CEN_POS_MAX + 1) mag = CEN_POS_MAX + 1;
         return CEN_W'(longint'(0) - longint'(mag));
      end
      if (mag > CEN_POS_MAX) mag = CEN_POS_MAX;
      return CEN_W'(mag);
   endfunction

   function automatic longint coord(logic [COORD_W-1:0] raw);
      return longint'(signed'(raw));
   endfunction

   always @(posedge clock) begin
      longint a [3], b [3], c [3];
      longint tri_prod, v;
      res_type exp_r, got_r;
      if (reset) begin
         mesh_results.delete();
         six_vol_acc = 0;
         moment_acc = '{0, 0, 0};
         tri_seen = 0;
         too_many = 0;
         errors <= 0;
         meshes_done <= 0;
         overflow_meshes <= 0;
         saturated_centres <= 0;
      end else begin
         if (push && !full) begin
            a = '{coord(req_ax), coord(req_ay), coord(req_az)};
            b = '{coord(req_bx), coord(req_by), coord(req_bz)};
            c = '{coord(req_cx), coord(req_cy), coord(req_cz)};
            if (tri_seen < MAX_TRIANGLES) begin
               tri_prod = a[0] * (b[1] * c[2] - b[2] * c[1])
                        + a[1] * (b[2] * c[0] - b[0] * c[2])
                        + a[2] * (b[0] * c[1] - b[1] * c[0]);
               six_vol_acc += tri_prod;
               for (int i = 0; i < 3; i++)
                  moment_acc[i] += tri_prod * (a[i] + b[i] + c[i]);
               tri_seen++;
            end else begin
               too_many = 1;
            end
            if (req_last_triangle) begin
               v = six_vol_acc;
               if (v > VOL_MAX) v = VOL_MAX;
               if (v < -VOL_MAX - 1) v = -VOL_MAX - 1;
               exp_r.six_volume = VOL_W'(v);
               exp_r.zero_volume = (six_vol_acc == 0);
               exp_r.count_overflow = too_many;
               exp_r.centre_x = exp_r.zero_volume ? '0 : centre_of(moment_acc[0], six_vol_acc);
               exp_r.centre_y = exp_r.zero_volume ? '0 : centre_of(moment_acc[1], six_vol_acc);
               exp_r.centre_z = exp_r.zero_volume ? '0 : centre_of(moment_acc[2], six_vol_acc);
               if (too_many) overflow_meshes <= overflow_meshes + 1;
               if (exp_r.centre_x == {1'b1, {(CEN_W-1){1'b0}}} ||
                   exp_r.centre_x == {1'b0, {(CEN_W-1){1'b1}}})
                  saturated_centres <= saturated_centres + 1;
               mesh_results.push_back(exp_r);
               six_vol_acc = 0;
               moment_acc = '{0, 0, 0};
               tri_seen = 0;
               too_many = 0;
            end
         end
         if (pop && !empty) begin
            got_r = '{rsp_six_volume, rsp_centre_x, rsp_centre_y, rsp_centre_z,
                      rsp_zero_volume, rsp_count_overflow};
            meshes_done <= meshes_done + 1;
            if (mesh_results.size() == 0) begin
               $display("%0t: unexpected result beat vol=%0d", $time, rsp_six_volume);
               errors <= errors + 1;
            end else begin
               exp_r = mesh_results.pop_front();
               if (got_r !== exp_r) begin
                  $display("%0t: mismatch exp vol=%0d c=(%0d,%0d,%0d) z=%0b o=%0b",
                           $time, exp_r.six_volume, exp_r.centre_x, exp_r.centre_y,
                           exp_r.centre_z, exp_r.zero_volume, exp_r.count_overflow);
                  $display("%0t:          got vol=%0d c=(%0d,%0d,%0d) z=%0b o=%0b",
                           $time, got_r.six_volume, got_r.centre_x, got_r.centre_y,
                           got_r.centre_z, got_r.zero_volume, got_r.count_overflow);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import mvca_pkg::*;

   localparam int MAX_TRI = 4096;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 0;
   logic reset = 1;
   logic push = 0;
   logic pop = 0;
   logic full, empty;
   logic [8:0][COORD_W-1:0] tri_pts = '0;
   logic last_tri = 0;
   logic signed [VOL_W-1:0] rsp_six_volume;
   logic signed [CEN_W-1:0] rsp_centre_x, rsp_centre_y, rsp_centre_z;
   logic rsp_zero_volume, rsp_count_overflow;

   int pending, errors, meshes_done, overflow_meshes, saturated_centres;
   int tris_sent = 0;
   int cycles = 0;
   bit tx_idle = 1;
   bit rx_idle = 1;
   bit rx_long_hold = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   mesh_volume_centroid_accumulator_unit #(.MAX_TRIANGLES(MAX_TRI), .COORD_BITS(COORD_W)) uut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_ax(tri_pts[0]), .req_ay(tri_pts[1]), .req_az(tri_pts[2]),
      .req_bx(tri_pts[3]), .req_by(tri_pts[4]), .req_bz(tri_pts[5]),
      .req_cx(tri_pts[6]), .req_cy(tri_pts[7]), .req_cz(tri_pts[8]),
      .req_last_triangle(last_tri), .empty(empty), .pop(pop),
      .rsp_six_volume(rsp_six_volume), .rsp_centre_x(rsp_centre_x),
      .rsp_centre_y(rsp_centre_y), .rsp_centre_z(rsp_centre_z),
      .rsp_zero_volume(rsp_zero_volume), .rsp_count_overflow(rsp_count_overflow)
   );

   mvca_checker #(.MAX_TRIANGLES(MAX_TRI)) u_checker (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_ax(tri_pts[0]), .req_ay(tri_pts[1]), .req_az(tri_pts[2]),
      .req_bx(tri_pts[3]), .req_by(tri_pts[4]), .req_bz(tri_pts[5]),
      .req_cx(tri_pts[6]), .req_cy(tri_pts[7]), .req_cz(tri_pts[8]),
      .req_last_triangle(last_tri), .empty(empty), .pop(pop),
      .rsp_six_volume(rsp_six_volume), .rsp_centre_x(rsp_centre_x),
      .rsp_centre_y(rsp_centre_y), .rsp_centre_z(rsp_centre_z),
      .rsp_zero_volume(rsp_zero_volume), .rsp_count_overflow(rsp_count_overflow),
      .pending(pending), .errors(errors), .meshes_done(meshes_done),
      .overflow_meshes(overflow_meshes), .saturated_centres(saturated_centres)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side
   initial begin
      int n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rx_long_hold) begin
            pop <= 0;
            repeat (400) @(posedge clock);
            rx_long_hold = 0;
         end
         n = rx_idle ? $urandom_range(0, 5) : 0;
         if (n > 0) begin
            pop <= 0;
            repeat (n) @(posedge clock);
         end
         pop <= 1;
         do @(posedge clock); while (empty);
      end
   end

   task automatic send_tri(input logic [8:0][COORD_W-1:0] pts, input bit lst);
      int n;
      n = tx_idle ? $urandom_range(0, 5) : 0;
      if (n > 0) begin
         push <= 0;
         repeat (n) @(posedge clock);
      end
      tri_pts <= pts;
      last_tri <= lst;
      push <= 1;
      do @(posedge clock); while (full);
      tris_sent++;
   endtask

   function automatic logic [COORD_W-1:0] pick_coord(int mode);
      case (mode)
         0: return COORD_W'($urandom);
         1: case ($urandom_range(0, 4))
               0: return 12'h800;
               1: return 12'h7ff;
               2: return 12'h000;
               3: return 12'hfff;
               default: return 12'h001;
            endcase
         default: return COORD_W'($urandom_range(0, 15) - 8);
      endcase
   endfunction

   task automatic send_mesh(input int len, input int mode);
      logic [8:0][COORD_W-1:0] pts;
      for (int t = 0; t < len; t++) begin
         for (int k = 0; k < 9; k++) pts[k] = pick_coord(mode);
         send_tri(pts, t == len - 1);
      end
   endtask

   function automatic logic [8:0][COORD_W-1:0] mk(int ax, int ay, int az, int bx, int by,
                                                   int bz, int cx, int cy, int cz);
      return {COORD_W'(cz), COORD_W'(cy), COORD_W'(cx), COORD_W'(bz), COORD_W'(by),
              COORD_W'(bx), COORD_W'(az), COORD_W'(ay), COORD_W'(ax)};
   endfunction

   task automatic wait_drained();
      push <= 0;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      int len, mode;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // zero volume, extremes and all-ones corners
      send_tri(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1);
      send_tri(mk(2047, 2047, 2047, -2048, -2048, -2048, 2047, -2048, 2047), 1);
      send_tri(mk(-2048, 0, 0, 0, -2048, 0, 0, 0, -2048), 1);
      send_tri(mk(2047, 0, 0, 0, 2047, 0, 0, 0, 2047), 1);
      send_tri(mk(-1, -1, -1, 1, 1, 1, -1, 1, -1), 1);
      // two big cancelling tetrahedra plus a unit one: x centre saturates high
      send_tri(mk(2047, 0, 0, 0, 2047, 0, 0, 0, 2047), 0);
      send_tri(mk(-2047, 0, 0, 0, 2047, 0, 0, 0, 2047), 0);
      send_tri(mk(1, 0, 0, 0, 1, 0, 0, 0, 1), 1);
      // same with negative unit volume: x centre saturates low
      send_tri(mk(2047, 0, 0, 0, 2047, 0, 0, 0, 2047), 0);
      send_tri(mk(-2047, 0, 0, 0, 2047, 0, 0, 0, 2047), 0);
      send_tri(mk(-1, 0, 0, 0, 1, 0, 0, 0, 1), 1);
      // cancelling mesh with nonzero per-triangle weights reports zero volume
      send_tri(mk(2047, 0, 0, 0, 2047, 0, 0, 0, 2047), 0);
      send_tri(mk(0, 2047, 0, 2047, 0, 0, 0, 0, 2047), 1);
      send_tri(mk(3, 1, 0, 0, 2, 1, 1, 0, 5), 0);
      send_tri(mk(-5, 7, 2, 4, -3, 1, 0, 6, -2), 1);
      wait_drained();

      // receiver stalls while single-triangle meshes pile up
      rx_long_hold = 1;
      tx_idle = 0;
      for (int m = 0; m < 20; m++) send_mesh(1, 0);
      tx_idle = 1;
      wait_drained();

      while (tris_sent < 1950) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         mode = $urandom_range(0, 2);
         tx_idle = $urandom_range(0, 3) != 0;
         rx_idle = $urandom_range(0, 3) != 0;
         send_mesh(len, mode);
      end
      push <= 0;

      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d triangles, checked %0d mesh results", tris_sent, meshes_done);
      $display("%0d meshes over the limit, %0d saturated x centres",
               overflow_meshes, saturated_centres);
      if (errors == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
